>>> sv/h264fua_pkg.sv
// ----------------------------------------------------------------------------
// h264fua_pkg
// Shared types and constants for the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package h264fua_pkg;

  localparam int unsigned LEN_BITS = 16;
  localparam int unsigned SEG_BITS = 11;
  localparam int unsigned TS_BITS  = 16;
  localparam int unsigned PT_BITS  = 7;
  localparam int unsigned MAX_RES  = 3;
  localparam int unsigned CNT_BITS = 2;
  localparam int unsigned IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  // configuration register indexes
  localparam logic [IDX_BITS-1:0] CFG_MAX_PAYLOAD   = 2'd0;
  localparam logic [IDX_BITS-1:0] CFG_FRAME_TS_STEP = 2'd1;
  localparam logic [IDX_BITS-1:0] CFG_PAYLOAD_KIND  = 2'd2;

  localparam logic [SEG_BITS-1:0] MAX_PAYLOAD_RST   = 11'd1400;
  localparam logic [TS_BITS-1:0]  FRAME_TS_STEP_RST = 16'd3600;
  localparam logic [PT_BITS-1:0]  PAYLOAD_KIND_RST  = 7'd100;

  localparam logic [4:0] FU_A_TYPE = 5'd28;
  localparam logic [4:0] NAL_TYPE_SLICE     = 5'd1;
  localparam logic [4:0] NAL_TYPE_IDR_SLICE = 5'd5;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_FRAG   = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e                mode;
    logic [7:0]           nal_header;
    logic [LEN_BITS-1:0]  bytes_left;
    logic [SEG_BITS-1:0]  fragment_fill;
    logic                 first_fragment;
    logic [SEG_BITS-1:0]  seg_size;
  } fua_state_t;

  typedef struct packed {
    logic [SEG_BITS-1:0] max_payload;
    logic [TS_BITS-1:0]  frame_ts_step;
  } fua_cfg_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               packet_start;
    logic               packet_end;
    logic               marker;
    logic [TS_BITS-1:0] ts_step;
  } fua_res_t;

endpackage

`default_nettype wire

>>> sv/h264fua_step.sv
// ----------------------------------------------------------------------------
// h264fua_step
// Next-state and result logic for one NAL byte: single packet or FU-A.
// ----------------------------------------------------------------------------
`default_nettype none

module h264fua_step import h264fua_pkg::*; (
  input  fua_state_t          state_i,
  input  fua_cfg_t            cfg_i,
  input  logic [7:0]          nal_byte_i,
  input  logic                first_of_nal_i,
  input  logic [15:0]         nal_length_i,
  output fua_state_t          state_o,
  output fua_res_t            res_o [MAX_RES],
  output logic [CNT_BITS-1:0] count_o
);

  logic [LEN_BITS-1:0] len_raw;
  logic [LEN_BITS-1:0] len;
  logic [SEG_BITS-1:0] seg;
  logic [LEN_BITS-1:0] left_dec;
  logic [SEG_BITS-1:0] fill_inc;
  logic [7:0]          hdr_cur;
  logic [TS_BITS-1:0]  slice_ts;
  logic [7:0]          fu_ind;
  logic [7:0]          fu_hdr;
  fua_res_t            data_res;
  fua_res_t            zero_res;

  assign len_raw  = nal_length_i[LEN_BITS-1:0];
  assign len      = (len_raw == '0) ? LEN_BITS'(1) : len_raw;
  assign seg      = (cfg_i.max_payload == '0) ? SEG_BITS'(1) : cfg_i.max_payload;
  assign left_dec = state_i.bytes_left - LEN_BITS'(1);
  assign fill_inc = state_i.fragment_fill + SEG_BITS'(1);

  // header in effect for this byte: a new one on the first byte
  assign hdr_cur  = first_of_nal_i ? nal_byte_i : state_i.nal_header;
  assign slice_ts = (hdr_cur[4:0] == NAL_TYPE_SLICE || hdr_cur[4:0] == NAL_TYPE_IDR_SLICE)
                    ? cfg_i.frame_ts_step : '0;

  assign fu_ind = {state_i.nal_header[7:5], FU_A_TYPE};
  assign fu_hdr = {state_i.first_fragment,
                   (state_i.bytes_left <= LEN_BITS'(state_i.seg_size)),
                   1'b0, state_i.nal_header[4:0]};

  assign zero_res = '{out_byte: 8'h00, packet_start: 1'b0, packet_end: 1'b0,
                      marker: 1'b0, ts_step: '0};

  always_comb begin
    state_o  = state_i;
    count_o  = '0;
    data_res = '{out_byte: nal_byte_i, packet_start: 1'b0, packet_end: 1'b0,
                 marker: 1'b0, ts_step: '0};
    for (int i = 0; i < MAX_RES; i++) begin
      res_o[i] = zero_res;
    end

    if (first_of_nal_i) begin
      state_o.seg_size       = seg;
      state_o.nal_header     = nal_byte_i;
      state_o.bytes_left     = len - LEN_BITS'(1);
      state_o.fragment_fill  = '0;
      state_o.first_fragment = 1'b1;
      if (len <= LEN_BITS'(seg)) begin
        data_res.packet_start = 1'b1;
        if (len == LEN_BITS'(1)) begin
          data_res.packet_end = 1'b1;
          data_res.marker     = 1'b1;
          data_res.ts_step    = slice_ts;
          state_o.mode        = MODE_IDLE;
        end else begin
          state_o.mode = MODE_SINGLE;
        end
        res_o[0] = data_res;
        count_o  = CNT_BITS'(1);
      end else begin
        state_o.mode = MODE_FRAG;
      end
    end else begin
      case (state_i.mode)
        MODE_SINGLE: begin
          state_o.bytes_left = left_dec;
          if (left_dec == '0) begin
            data_res.packet_end = 1'b1;
            data_res.marker     = 1'b1;
            data_res.ts_step    = slice_ts;
            state_o.mode        = MODE_IDLE;
          end
          res_o[0] = data_res;
          count_o  = CNT_BITS'(1);
        end
        MODE_FRAG: begin
          state_o.bytes_left     = left_dec;
          state_o.fragment_fill  = fill_inc;
          if (left_dec == '0) begin
            data_res.packet_end   = 1'b1;
            data_res.marker       = 1'b1;
            data_res.ts_step      = cfg_i.frame_ts_step;
            state_o.fragment_fill = '0;
            state_o.mode          = MODE_IDLE;
          end else if (fill_inc >= state_i.seg_size) begin
            data_res.packet_end   = 1'b1;
            state_o.fragment_fill = '0;
          end
          if (state_i.fragment_fill == '0) begin
            // fragment opens: FU indicator and FU header go out first
            res_o[0] = '{out_byte: fu_ind, packet_start: 1'b1, packet_end: 1'b0,
                         marker: 1'b0, ts_step: '0};
            res_o[1] = '{out_byte: fu_hdr, packet_start: 1'b0, packet_end: 1'b0,
                         marker: 1'b0, ts_step: '0};
            res_o[2] = data_res;
            count_o  = CNT_BITS'(3);
            state_o.first_fragment = 1'b0;
          end else begin
            res_o[0] = data_res;
            count_o  = CNT_BITS'(1);
          end
        end
        default: begin
          // stray byte outside a unit: dropped
          count_o = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/h264_rtp_fua_packetizer_core.sv
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer_core
// H.264 RTP payload packetizer: single NAL unit packets and FU-A fragments.
// ----------------------------------------------------------------------------
// One NAL byte is taken per request and its results (at most three) are
// loaded into a result register that drives the output one byte per cycle
// unless the output stalls. Plain data bytes pass at one byte per cycle
// likewise. The first data byte of each FU-A fragment yields three bytes
// (FU indicator, FU header, data), so the input holds off until all three
// have been taken; a fragmented NAL's header byte yields nothing. Throughput
// is set by the single output port draining the result register; the next
// request is taken in the same cycle the last result of the current one is taken.
`default_nettype none

module h264_rtp_fua_packetizer_core import h264fua_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [IDX_BITS-1:0]      cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               nal_byte_i,
  input  logic                     first_of_nal_i,
  input  logic [15:0]              nal_length_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               out_byte_o,
  output logic                     packet_start_o,
  output logic                     packet_end_o,
  output logic                     marker_o,
  output logic [TS_BITS-1:0]       ts_step_o,
  output logic [PT_BITS-1:0]       payload_type_o,
  output logic                     run_last_o
);

  fua_cfg_t            cfg_q;
  logic [PT_BITS-1:0]  payload_kind_q;
  fua_state_t          state_q, state_d;
  fua_res_t            res_d [MAX_RES];
  fua_res_t            res_q [MAX_RES];
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [IDX_BITS-1:0] idx_q;
  logic [PT_BITS-1:0]  pt_q;
  logic                in_acc;
  logic                pop;
  logic                last_pop;
  fua_res_t            cur;

  h264fua_step u_step (
    .state_i        (state_q),
    .cfg_i          (cfg_q),
    .nal_byte_i     (nal_byte_i),
    .first_of_nal_i (first_of_nal_i),
    .nal_length_i   (nal_length_i),
    .state_o        (state_d),
    .res_o          (res_d),
    .count_o        (cnt_d)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload   <= MAX_PAYLOAD_RST;
      cfg_q.frame_ts_step <= FRAME_TS_STEP_RST;
      payload_kind_q      <= PAYLOAD_KIND_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_PAYLOAD:   cfg_q.max_payload   <= cfg_data_i[SEG_BITS-1:0];
        CFG_FRAME_TS_STEP: cfg_q.frame_ts_step <= cfg_data_i[TS_BITS-1:0];
        CFG_PAYLOAD_KIND:  payload_kind_q      <= cfg_data_i[PT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cur      = res_q[idx_q];
  assign pop      = out_valid_o && out_ready_i;
  assign last_pop = pop && (CNT_BITS'(idx_q) == cnt_q - CNT_BITS'(1));
  assign in_ready_o = (cnt_q == '0) || last_pop;
  assign in_acc   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: MODE_IDLE, nal_header: 8'h00, bytes_left: '0,
                   fragment_fill: '0, first_fragment: 1'b1,
                   seg_size: MAX_PAYLOAD_RST};
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
        cnt_q   <= cnt_d;
        idx_q   <= '0;
      end else if (last_pop) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else if (pop) begin
        idx_q <= idx_q + IDX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
      pt_q  <= payload_kind_q;
    end
  end

  assign out_valid_o    = (cnt_q != '0);
  assign out_byte_o     = cur.out_byte;
  assign packet_start_o = cur.packet_start;
  assign packet_end_o   = cur.packet_end;
  assign marker_o       = cur.marker;
  assign ts_step_o      = cur.ts_step;
  assign payload_type_o = pt_q;
  assign run_last_o     = (CNT_BITS'(idx_q) == cnt_q - CNT_BITS'(1));

  // read pointer always inside the loaded burst
  a_idx_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CNT_BITS'(idx_q) < cnt_q))
    else $error("result index beyond burst");

  // a new request only lands on an empty or draining result register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && out_valid_o) |-> last_pop)
    else $error("request taken over pending results");

  // marker only ever closes a packet
  a_marker_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && marker_o) |-> packet_end_o)
    else $error("marker without packet end");

  // fragment fill stays below the segment size sampled for the unit
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == MODE_FRAG) |-> (state_q.fragment_fill < state_q.seg_size))
    else $error("fragment fill overran segment size");

  // burst not taken stays put
  a_hold_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(idx_q) && $stable(cnt_q)))
    else $error("burst changed while stalled");

endmodule

`default_nettype wire

>>> tb/sv/h264_rtp_fua_packetizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer_core_tb
// Self-checking testbench for the H.264 RTP FU-A packetizer core.
// ----------------------------------------------------------------------------
// NAL bytes are pushed through the input request channel. A behavioral
// packetizer in this file works out the payload bytes each request causes,
// and every output request is compared with the oldest expected byte.
// A short directed table comes first, then mixed NAL streams under several
// register settings, with random stalls on both sides and one long output
// hold-off per phase where noted.
// ----------------------------------------------------------------------------

module h264_rtp_fua_packetizer_core_tb;
  import h264fua_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int SETTLE_CYC = 8;
  localparam int HOLD_CYC   = 300;
  localparam int TIMEOUT_NS = 2_000_000;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               packet_start;
    logic               packet_end;
    logic               marker;
    logic [TS_BITS-1:0] ts_step;
    logic [PT_BITS-1:0] payload_type;
    logic               run_last;
  } payload_byte_t;

  typedef enum logic [1:0] {TAG_PREDICT, TAG_NONE, TAG_ONE} tag_e;
  typedef enum logic {ROW_BYTE, ROW_REG} row_e;

  // register rows keep the index in nbyte and the write data in value
  typedef struct packed {
    row_e          kind;
    logic          hdr_flag;
    logic [7:0]    nbyte;
    logic [15:0]   value;
    tag_e          tag;
    payload_byte_t res;
  } stim_row_t;

  localparam payload_byte_t NO_RES = '0;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_valid   = 1'b0;
  logic                     cfg_ready_o;
  logic [IDX_BITS-1:0]      cfg_index   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data    = '0;
  logic                     in_valid    = 1'b0;
  logic                     in_ready_o;
  logic [7:0]               nal_byte    = '0;
  logic                     hdr_flag    = 1'b0;
  logic [15:0]              nal_length  = '0;
  logic                     out_valid_o;
  logic                     out_ready   = 1'b0;
  logic [7:0]               out_byte_o;
  logic                     packet_start_o;
  logic                     packet_end_o;
  logic                     marker_o;
  logic [TS_BITS-1:0]       ts_step_o;
  logic [PT_BITS-1:0]       payload_type_o;
  logic                     run_last_o;

  // travels with each request: how its results are expected
  tag_e          tag_kind = TAG_PREDICT;
  payload_byte_t tag_res  = '0;

  h264_rtp_fua_packetizer_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .nal_byte_i     (nal_byte),
    .first_of_nal_i (hdr_flag),
    .nal_length_i   (nal_length),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte_o),
    .packet_start_o (packet_start_o),
    .packet_end_o   (packet_end_o),
    .marker_o       (marker_o),
    .ts_step_o      (ts_step_o),
    .payload_type_o (payload_type_o),
    .run_last_o     (run_last_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // packetizer state and register copies
  logic [SEG_BITS-1:0] cur_max_payload = MAX_PAYLOAD_RST;
  logic [TS_BITS-1:0]  cur_ts_step     = FRAME_TS_STEP_RST;
  logic [PT_BITS-1:0]  cur_pt          = PAYLOAD_KIND_RST;
  mode_e               st_mode         = MODE_IDLE;
  logic [7:0]          st_hdr          = '0;
  logic [LEN_BITS-1:0] st_left         = '0;
  logic [SEG_BITS-1:0] st_fill         = '0;
  logic                st_first        = 1'b1;
  logic [SEG_BITS-1:0] st_seg          = MAX_PAYLOAD_RST;

  payload_byte_t step_q[$];
  payload_byte_t pending_bytes[$];

  int fail_cnt   = 0;
  int bytes_in   = 0;
  int stray_cnt  = 0;
  int bytes_out  = 0;
  int reg_writes = 0;
  int tx_gap_max = 7;
  int rx_gap_max = 7;
  int rx_hold    = 0;

  function automatic void emit(logic [7:0] b, logic st, logic en, logic mk,
                               logic [TS_BITS-1:0] ts);
    payload_byte_t r;
    r = '{b, st, en, mk, ts, cur_pt, 1'b0};
    step_q.push_back(r);
  endfunction

  function automatic logic [TS_BITS-1:0] slice_step();
    return (st_hdr[4:0] == NAL_TYPE_SLICE || st_hdr[4:0] == NAL_TYPE_IDR_SLICE) ?
           cur_ts_step : '0;
  endfunction

  function automatic void packetize_byte(logic [7:0] b, logic is_hdr,
                                         logic [15:0] len_in);
    logic [LEN_BITS-1:0] len;
    logic [7:0]          fu_hdr;
    step_q.delete();
    if (is_hdr) begin
      len      = (len_in == '0) ? LEN_BITS'(1) : len_in;
      st_seg   = (cur_max_payload == '0) ? SEG_BITS'(1) : cur_max_payload;
      st_hdr   = b;
      st_left  = len - 1'b1;
      st_fill  = '0;
      st_first = 1'b1;
      if (len <= st_seg) begin
        if (st_left == '0) begin
          emit(b, 1'b1, 1'b1, 1'b1, slice_step());
          st_mode = MODE_IDLE;
        end else begin
          emit(b, 1'b1, 1'b0, 1'b0, '0);
          st_mode = MODE_SINGLE;
        end
      end else begin
        st_mode = MODE_FRAG;  // nothing goes out until the first data byte
      end
    end else if (st_mode == MODE_SINGLE) begin
      st_left = st_left - 1'b1;
      if (st_left == '0) begin
        emit(b, 1'b0, 1'b1, 1'b1, slice_step());
        st_mode = MODE_IDLE;
      end else begin
        emit(b, 1'b0, 1'b0, 1'b0, '0);
      end
    end else if (st_mode == MODE_FRAG) begin
      if (st_fill == '0) begin
        // E is set as soon as the rest fits, so no empty fragment follows
        fu_hdr = {st_first, (st_left <= st_seg), 1'b0, st_hdr[4:0]};
        emit({st_hdr[7:5], FU_A_TYPE}, 1'b1, 1'b0, 1'b0, '0);
        emit(fu_hdr, 1'b0, 1'b0, 1'b0, '0);
        st_first = 1'b0;
      end
      st_left = st_left - 1'b1;
      st_fill = st_fill + 1'b1;
      if (st_left == '0) begin
        emit(b, 1'b0, 1'b1, 1'b1, cur_ts_step);
        st_fill = '0;
        st_mode = MODE_IDLE;
      end else if (st_fill >= st_seg) begin
        emit(b, 1'b0, 1'b1, 1'b0, '0);
        st_fill = '0;
      end else begin
        emit(b, 1'b0, 1'b0, 1'b0, '0);
      end
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : scoreboard
    payload_byte_t want;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        case (cfg_index)
          CFG_MAX_PAYLOAD:   cur_max_payload = cfg_data[SEG_BITS-1:0];
          CFG_FRAME_TS_STEP: cur_ts_step     = cfg_data[TS_BITS-1:0];
          CFG_PAYLOAD_KIND:  cur_pt          = cfg_data[PT_BITS-1:0];
          default: ;
        endcase
        reg_writes++;
      end
      if (in_valid && in_ready_o) begin
        bytes_in++;
        if (!hdr_flag && st_mode == MODE_IDLE) stray_cnt++;
        packetize_byte(nal_byte, hdr_flag, nal_length);
        case (tag_kind)
          TAG_PREDICT: foreach (step_q[k]) pending_bytes.push_back(step_q[k]);
          TAG_ONE:     pending_bytes.push_back(tag_res);
          default: ;
        endcase
      end
      if (out_valid_o && out_ready) begin
        bytes_out++;
        if (pending_bytes.size() == 0) begin
          $error("unexpected payload byte 0x%02h", out_byte_o);
          fail_cnt++;
        end else begin
          want = pending_bytes.pop_front();
          check_field("out_byte",     want.out_byte,     out_byte_o);
          check_field("packet_start", want.packet_start, packet_start_o);
          check_field("packet_end",   want.packet_end,   packet_end_o);
          check_field("marker",       want.marker,       marker_o);
          check_field("ts_step",      want.ts_step,      ts_step_o);
          check_field("payload_type", want.payload_type, payload_type_o);
          check_field("run_last",     want.run_last,     run_last_o);
        end
      end
    end
  end

  // output side: random stall per byte, or one long hold-off when asked
  initial begin : receiver
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = $urandom_range(0, rx_gap_max);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_byte(logic is_hdr, logic [7:0] b, logic [15:0] len,
                           tag_e tag, payload_byte_t res);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    hdr_flag   <= is_hdr;
    nal_byte   <= b;
    nal_length <= len;
    tag_kind   <= tag;
    tag_res    <= res;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // sample on the falling edge so the scoreboard has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending_bytes.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_regs(int mp, int ts, int pt);
    drain_results();
    write_reg(CFG_MAX_PAYLOAD, CFG_DATA_BITS'(mp));
    write_reg(CFG_FRAME_TS_STEP, CFG_DATA_BITS'(ts));
    write_reg(CFG_PAYLOAD_KIND, CFG_DATA_BITS'(pt));
    cfg_valid <= 1'b0;
  endtask

  // mostly complete NAL units with random content; the rest strays,
  // truncated units and headers whose declared length is never reached
  task automatic run_nal_mix(int n_items);
    int sent;
    int seg_now;
    int len;
    int ndata;
    int pick;
    logic [7:0]  hdr;
    logic [15:0] len_field;
    sent = 0;
    while (sent < n_items) begin
      pick    = $urandom_range(0, 19);
      seg_now = (cur_max_payload == '0) ? 1 : int'(cur_max_payload);
      if (pick == 0) begin
        send_byte(1'b0, 8'($urandom), 16'($urandom), TAG_PREDICT, NO_RES);
        sent++;
      end else if (pick == 1) begin
        drain_results();
      end else begin
        hdr = 8'($urandom);
        if ($urandom_range(0, 1) == 1)
          hdr[4:0] = ($urandom_range(0, 1) == 1) ? NAL_TYPE_SLICE : NAL_TYPE_IDR_SLICE;
        len       = $urandom_range(1, (seg_now * 3 + 2 > 40) ? 40 : seg_now * 3 + 2);
        ndata     = len - 1;
        len_field = 16'(len);
        if (pick == 2) begin
          len_field = 16'($urandom);
          ndata     = $urandom_range(0, 4);
        end else if (pick == 3) begin
          ndata = $urandom_range(0, ndata);
        end else if (pick == 4) begin
          len_field = '0;
          ndata     = 0;
        end
        // the phase budget cuts the last unit short
        if (ndata > n_items - sent - 1) ndata = n_items - sent - 1;
        send_byte(1'b1, hdr, len_field, TAG_PREDICT, NO_RES);
        sent++;
        repeat (ndata) begin
          send_byte(1'b0, 8'($urandom), 16'($urandom), TAG_PREDICT, NO_RES);
          sent++;
        end
      end
    end
  endtask

  stim_row_t dir_tab [24];

  initial begin : stimulus
    dir_tab = '{
      // byte outside a unit is dropped
      '{ROW_BYTE, 1'b0, 8'hAA, 16'd0,   TAG_NONE, NO_RES},
      '{ROW_BYTE, 1'b1, 8'h65, 16'd1,   TAG_ONE,
        '{8'h65, 1'b1, 1'b1, 1'b1, 16'd3600, 7'd100, 1'b1}},
      // zero length counts as header only
      '{ROW_BYTE, 1'b1, 8'h67, 16'd0,   TAG_ONE,
        '{8'h67, 1'b1, 1'b1, 1'b1, 16'd0, 7'd100, 1'b1}},
      '{ROW_BYTE, 1'b1, 8'h41, 16'd3,   TAG_ONE,
        '{8'h41, 1'b1, 1'b0, 1'b0, 16'd0, 7'd100, 1'b1}},
      '{ROW_BYTE, 1'b0, 8'h00, 16'd0,   TAG_ONE,
        '{8'h00, 1'b0, 1'b0, 1'b0, 16'd0, 7'd100, 1'b1}},
      '{ROW_BYTE, 1'b0, 8'hFF, 16'd0,   TAG_ONE,
        '{8'hFF, 1'b0, 1'b1, 1'b1, 16'd3600, 7'd100, 1'b1}},
      '{ROW_BYTE, 1'b1, 8'hE1, 16'd4,   TAG_ONE,
        '{8'hE1, 1'b1, 1'b0, 1'b0, 16'd0, 7'd100, 1'b1}},
      '{ROW_BYTE, 1'b0, 8'h12, 16'd0,   TAG_PREDICT, NO_RES},
      // new header abandons the open single packet
      '{ROW_BYTE, 1'b1, 8'h06, 16'd2,   TAG_ONE,
        '{8'h06, 1'b1, 1'b0, 1'b0, 16'd0, 7'd100, 1'b1}},
      '{ROW_BYTE, 1'b0, 8'h34, 16'd0,   TAG_ONE,
        '{8'h34, 1'b0, 1'b1, 1'b1, 16'd0, 7'd100, 1'b1}},
      '{ROW_REG,  1'b0, 8'(CFG_MAX_PAYLOAD), 16'd2, TAG_NONE, NO_RES},
      // two data bytes fit one fragment: S and E together
      '{ROW_BYTE, 1'b1, 8'h65, 16'd3,   TAG_NONE, NO_RES},
      '{ROW_BYTE, 1'b0, 8'h11, 16'd0,   TAG_PREDICT, NO_RES},
      '{ROW_BYTE, 1'b0, 8'h22, 16'd0,   TAG_PREDICT, NO_RES},
      '{ROW_BYTE, 1'b1, 8'hFF, 16'hFFFF, TAG_NONE, NO_RES},
      '{ROW_BYTE, 1'b0, 8'h80, 16'd0,   TAG_PREDICT, NO_RES},
      '{ROW_BYTE, 1'b0, 8'h01, 16'd0,   TAG_PREDICT, NO_RES},
      '{ROW_BYTE, 1'b0, 8'h7F, 16'd0,   TAG_PREDICT, NO_RES},
      '{ROW_BYTE, 1'b0, 8'h55, 16'd0,   TAG_PREDICT, NO_RES},
      // data a multiple of the segment: E moves to the last full fragment
      '{ROW_BYTE, 1'b1, 8'h45, 16'd5,   TAG_NONE, NO_RES},
      '{ROW_BYTE, 1'b0, 8'hA5, 16'd0,   TAG_PREDICT, NO_RES},
      '{ROW_BYTE, 1'b0, 8'h5A, 16'd0,   TAG_PREDICT, NO_RES},
      '{ROW_BYTE, 1'b0, 8'hC3, 16'd0,   TAG_PREDICT, NO_RES},
      '{ROW_BYTE, 1'b0, 8'h3C, 16'd0,   TAG_PREDICT, NO_RES}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        drain_results();
        write_reg(IDX_BITS'(dir_tab[i].nbyte), dir_tab[i].value);
        cfg_valid <= 1'b0;
      end else begin
        send_byte(dir_tab[i].hdr_flag, dir_tab[i].nbyte, dir_tab[i].value,
                  dir_tab[i].tag, dir_tab[i].res);
      end
    end

    // two-byte segment, lowest step and type; output held off once
    set_regs(2, 0, 0);
    rx_hold = HOLD_CYC;
    run_nal_mix(34);

    // large segment, largest step and type, both sides at full rate
    set_regs(1498, 16'hFFFF, 127);
    tx_gap_max = 0;
    rx_gap_max = 0;
    run_nal_mix(34);
    tx_gap_max = 7;
    rx_gap_max = 7;

    set_regs($urandom_range(3, 12), $urandom_range(0, 65535), $urandom_range(0, 127));
    rx_hold = HOLD_CYC;
    run_nal_mix(34);

    // zero segment size acts as one
    set_regs(0, $urandom_range(0, 65535), $urandom_range(0, 127));
    run_nal_mix(34);

    drain_results();

    $display("Sent %0d NAL bytes (%0d dropped outside a unit), checked %0d payload bytes,",
             bytes_in, stray_cnt, bytes_out);
    $display("  with %0d register writes over six register settings", reg_writes);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("Regression FAIL");
    $finish;
  end

endmodule
